// ===== rtl/asp_pkg.sv =====
// shared types, widths and saturation helpers for the aliquot sum block
// no dependencies; imported by asp_div, asp_seq, aliquot_sum_perfect_test and both tb files
package asp_pkg;

    localparam int NUM_BITS = 31;
    localparam int DIV_W    = NUM_BITS / 2 + 2;
    localparam int STEP_W   = $clog2(NUM_BITS);
    localparam int CNT_W    = 11;
    localparam int SUM_W    = 34;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [DIV_W-1:0] I_START = DIV_W'(2);

    typedef logic [NUM_BITS-1:0] num_t;
    typedef logic [DIV_W-1:0]    div_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [SUM_W-1:0]    sum_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_ISSUE,
        SEQ_WAIT,
        SEQ_FINISH
    } seq_state_t;

    typedef struct packed {
        logic start;
        num_t dividend;
        div_t divisor;
    } div_req_t;

    typedef struct packed {
        logic done;
        num_t quotient;
        div_t remainder;
    } div_rsp_t;

    typedef struct packed {
        logic valid;
        cnt_t count;
        sum_t sum;
        logic perfect;
    } res_t;

    function automatic cnt_t sat_cnt(input logic [CNT_W:0] value);
        cnt_t result;
        result = value[CNT_W] ? CNT_MAX : value[CNT_W-1:0];
        return result;
    endfunction

    function automatic sum_t sat_sum(input logic [SUM_W:0] value);
        sum_t result;
        result = value[SUM_W] ? SUM_MAX : value[SUM_W-1:0];
        return result;
    endfunction

endpackage

// ===== rtl/asp_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on asp_pkg for widths and the request / response structs
module asp_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  asp_pkg::div_req_t req,
    output asp_pkg::div_rsp_t rsp
);
    import asp_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    num_t              quo_reg, quo_next;
    div_t              rem_reg, rem_next;
    div_t              dvs_reg, dvs_next;

    logic [DIV_W:0]    trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[NUM_BITS-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (busy_reg) begin
            quo_next = {quo_reg[NUM_BITS-2:0], fits};
            if (fits) begin
                rem_next = DIV_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(NUM_BITS - 1);
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign rsp = {done_reg, quo_reg, rem_reg};

endmodule

// ===== rtl/asp_seq.sv =====
// trial-division sequencer: steps the divisor, accumulates count and sum
// depends on asp_pkg; drives the shared asp_div through div_req_t / div_rsp_t
module asp_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  asp_pkg::num_t     s_number,
    output asp_pkg::div_req_t req,
    input  asp_pkg::div_rsp_t rsp,
    output asp_pkg::res_t     res,
    input  logic              res_take
);
    import asp_pkg::*;

    seq_state_t state_reg, state_next;
    num_t       n_reg, n_next;
    div_t       i_reg, i_next;
    cnt_t       cnt_reg, cnt_next;
    sum_t       sum_reg, sum_next;

    div_t       i_inc;
    logic       stop;
    logic       hit;
    logic       square;
    cnt_t       cnt_fin;
    sum_t       sum_fin;

    assign i_inc   = i_reg + 1'b1;
    assign stop    = rsp.quotient < NUM_BITS'(i_reg);
    assign hit     = rsp.remainder == '0;
    assign square  = rsp.quotient == NUM_BITS'(i_reg);
    assign cnt_fin = sat_cnt({1'b0, cnt_reg} + (CNT_W+1)'(1));
    assign sum_fin = sat_sum({1'b0, sum_reg} + (SUM_W+1)'(1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (s_valid) begin
                    state_next = SEQ_ISSUE;
                end
            end
            SEQ_ISSUE: begin
                state_next = SEQ_WAIT;
            end
            SEQ_WAIT: begin
                if (rsp.done && stop) begin
                    state_next = SEQ_FINISH;
                end
            end
            SEQ_FINISH: begin
                if (res_take) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_ready      = 1'b0;
        req.start    = 1'b0;
        req.dividend = n_reg;
        req.divisor  = i_reg;
        res.valid    = 1'b0;
        res.count    = cnt_fin;
        res.sum      = sum_fin;
        res.perfect  = sum_fin == SUM_W'(n_reg);
        unique case (state_reg)
            SEQ_IDLE: begin
                s_ready = 1'b1;
            end
            SEQ_ISSUE: begin
                req.start = 1'b1;
            end
            SEQ_WAIT: begin
                // chain the next trial straight off the finished division
                req.start   = rsp.done && !stop;
                req.divisor = i_inc;
            end
            SEQ_FINISH: begin
                res.valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb begin
        n_next   = n_reg;
        i_next   = i_reg;
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        if (state_reg == SEQ_IDLE && s_valid) begin
            n_next   = s_number;
            i_next   = I_START;
            cnt_next = '0;
            sum_next = '0;
        end else if (state_reg == SEQ_WAIT && rsp.done && !stop) begin
            i_next = i_inc;
            if (hit) begin
                if (square) begin
                    cnt_next = sat_cnt({1'b0, cnt_reg} + (CNT_W+1)'(1));
                    sum_next = sat_sum({1'b0, sum_reg} + (SUM_W+1)'(i_reg));
                end else begin
                    cnt_next = sat_cnt({1'b0, cnt_reg} + (CNT_W+1)'(2));
                    sum_next = sat_sum({1'b0, sum_reg} + (SUM_W+1)'(i_reg)
                                       + (SUM_W+1)'(rsp.quotient));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
        n_reg   <= n_next;
        i_reg   <= i_next;
        cnt_reg <= cnt_next;
        sum_reg <= sum_next;
    end

`ifndef SYNTHESIS
    a_start_single: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> !req.start)
        else $error("divider started on consecutive cycles");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> state_reg == SEQ_WAIT)
        else $error("division finished outside the wait state");

    a_divisor_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == SEQ_WAIT |-> i_reg >= I_START)
        else $error("trial divisor below two");

    a_result_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        res.valid |-> res.count != '0 && res.sum != '0)
        else $error("result misses the divisor one");
`endif

endmodule

// ===== rtl/aliquot_sum_perfect_test.sv =====
// top level of the aliquot sum / perfect number test
// depends on asp_pkg, asp_div and asp_seq; holds the result output register
//
// usage:
//   s_valid / s_ready / s_number carry one request, the number n to analyze
//   m_valid / m_ready carry the result: m_divisor_count (proper divisors
//   counting one), m_divisor_sum (aliquot sum, saturating) and m_is_perfect
//   s_ready is high only while the sequencer is idle; one request at a time
//   each trial divisor, counting up from i = 2, runs one division on the shared
//   one-bit-per-cycle divider; trials run until n / i < i, and the sequencer
//   takes no new request until its result has moved to the output register
//   the finished result moves to an output register, so a new request is
//   taken while the previous result still waits for m_ready
//   a stalled receiver holds the result; the sequencer waits in its final
//   state until the output register frees up
//   reset (aresetn low, synchronous) returns to idle and drops m_valid
module aliquot_sum_perfect_test (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [asp_pkg::NUM_BITS-1:0] s_number,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [asp_pkg::CNT_W-1:0]   m_divisor_count,
    output logic [asp_pkg::SUM_W-1:0]   m_divisor_sum,
    output logic                        m_is_perfect
);
    import asp_pkg::*;

    div_req_t div_req;
    div_rsp_t div_rsp;
    res_t     res;
    logic     res_take;

    logic     m_valid_reg, m_valid_next;
    cnt_t     count_reg, count_next;
    sum_t     sum_reg, sum_next;
    logic     perfect_reg, perfect_next;

    asp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    asp_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_number (s_number),
        .req      (div_req),
        .rsp      (div_rsp),
        .res      (res),
        .res_take (res_take)
    );

    assign res_take = res.valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        perfect_next = perfect_reg;
        if (res_take) begin
            m_valid_next = 1'b1;
            count_next   = res.count;
            sum_next     = res.sum;
            perfect_next = res.perfect;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        count_reg   <= count_next;
        sum_reg     <= sum_next;
        perfect_reg <= perfect_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_divisor_count = count_reg;
    assign m_divisor_sum   = sum_reg;
    assign m_is_perfect    = perfect_reg;

endmodule

// ===== tb/aliquot_checker.sv =====
// result checker for the aliquot sum / perfect number block
// watches both handshakes, predicts each result by trial division and compares
// depends on asp_pkg for the field widths and saturation limits
`timescale 1ns / 1ps

module aliquot_checker (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_ready,
    input  asp_pkg::num_t s_number,
    input  logic          m_valid,
    input  logic          m_ready,
    input  asp_pkg::cnt_t m_divisor_count,
    input  asp_pkg::sum_t m_divisor_sum,
    input  logic          m_is_perfect,
    output int            mismatches,
    output int            outstanding
);
    import asp_pkg::*;

    typedef struct {
        num_t number;
        cnt_t count;
        sum_t sum;
        logic perfect;
    } aliquot_t;

    aliquot_t aliquot_q[$];
    int       fail_count = 0;
    int       wait_count = 0;

    assign mismatches  = fail_count;
    assign outstanding = wait_count;

    function automatic aliquot_t aliquot_of(input num_t n);
        longint unsigned value;
        longint unsigned trial;
        longint unsigned quot;
        longint unsigned cnt;
        longint unsigned total;
        aliquot_t        r;
        value = n;
        cnt   = 0;
        total = 0;
        for (trial = 2; trial * trial <= value; trial++) begin
            if (value % trial == 0) begin
                quot = value / trial;
                if (quot != trial) begin
                    cnt   += 2;
                    total += trial + quot;
                end else begin
                    cnt   += 1;
                    total += trial;
                end
            end
        end
        cnt   += 1;
        total += 1;
        if (cnt > CNT_MAX) begin
            cnt = CNT_MAX;
        end
        if (total > SUM_MAX) begin
            total = SUM_MAX;
        end
        r.number  = n;
        r.count   = cnt_t'(cnt);
        r.sum     = sum_t'(total);
        r.perfect = (total == value);
        return r;
    endfunction

    always @(posedge aclk) begin
        aliquot_t want;
        if (!aresetn) begin
            aliquot_q.delete();
            wait_count <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (aliquot_q.size() == 0) begin
                    $display("%0t: result with no request pending, count %0d sum %0d perfect %0b",
                             $time, m_divisor_count, m_divisor_sum, m_is_perfect);
                    fail_count++;
                end else begin
                    want = aliquot_q.pop_front();
                    if (m_divisor_count !== want.count) begin
                        $display("%0t: n=%0d divisor_count expected %0d actual %0d",
                                 $time, want.number, want.count, m_divisor_count);
                        fail_count++;
                    end
                    if (m_divisor_sum !== want.sum) begin
                        $display("%0t: n=%0d divisor_sum expected %0d actual %0d",
                                 $time, want.number, want.sum, m_divisor_sum);
                        fail_count++;
                    end
                    if (m_is_perfect !== want.perfect) begin
                        $display("%0t: n=%0d is_perfect expected %0b actual %0b",
                                 $time, want.number, want.perfect, m_is_perfect);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                aliquot_q.push_back(aliquot_of(s_number));
            end
            wait_count <= aliquot_q.size();
        end
    end

endmodule

// ===== tb/tb_aliquot_sum_perfect_test.sv =====
// testbench top for the aliquot sum / perfect number block
// drives directed and random numbers under changing idle patterns on both sides
// depends on asp_pkg, the block itself and aliquot_checker
`timescale 1ns / 1ps

module tb_aliquot_sum_perfect_test;

    import asp_pkg::*;

    logic aclk     = 1'b0;
    logic aresetn  = 1'b0;
    logic s_valid  = 1'b0;
    logic s_ready;
    num_t s_number = '0;
    logic m_valid;
    logic m_ready  = 1'b0;
    cnt_t m_divisor_count;
    sum_t m_divisor_sum;
    logic m_is_perfect;

    int   mismatches;
    int   outstanding;
    int   src_idle_pct = 38;
    int   snk_idle_pct = 62;

    num_t directed_numbers[] = '{
        31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd6, 31'd9, 31'd12, 31'd16, 31'd25,
        31'd28, 31'd36, 31'd97, 31'd121, 31'd220, 31'd284, 31'd496, 31'd945,
        31'd1024, 31'd8128, 31'd65535, 31'd33550336, 31'h7fff_ffff
    };

    aliquot_sum_perfect_test u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_number        (s_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_divisor_count (m_divisor_count),
        .m_divisor_sum   (m_divisor_sum),
        .m_is_perfect    (m_is_perfect)
    );

    aliquot_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_number        (s_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_divisor_count (m_divisor_count),
        .m_divisor_sum   (m_divisor_sum),
        .m_is_perfect    (m_is_perfect),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // mostly small numbers, with squares and products for many divisors
    function automatic num_t pick_number();
        int unsigned mode;
        int unsigned a;
        int unsigned b;
        mode = $urandom_range(99);
        if (mode < 40) begin
            return num_t'($urandom_range(4095));
        end else if (mode < 55) begin
            a = $urandom_range(300, 2);
            return num_t'(a * a);
        end else if (mode < 75) begin
            a = $urandom_range(64, 2);
            b = $urandom_range(1024, 2);
            return num_t'(a * b);
        end else if (mode < 95) begin
            return num_t'($urandom_range(32'h3_ffff, 32'h1000));
        end
        return num_t'($urandom_range(32'h3f_ffff, 32'h4_0000));
    endfunction

    task automatic send_request(input num_t value);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_number <= value;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_numbers[k]) begin
            send_request(directed_numbers[k]);
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 38;
                    snk_idle_pct = 62;
                end
                1: begin
                    src_idle_pct = 62;
                    snk_idle_pct = 38;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            repeat (26) begin
                send_request(pick_number());
            end
        end
        s_valid <= 1'b0;

        while (outstanding != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_aliquot_sum_perfect_test: done, clean");
        end else begin
            $display("tb_aliquot_sum_perfect_test: done, errors");
        end
        $finish;
    end

    initial begin
        #400_000_000;
        $display("tb_aliquot_sum_perfect_test: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/asp_pkg.sv
rtl/asp_div.sv
rtl/asp_seq.sv
rtl/aliquot_sum_perfect_test.sv
tb/aliquot_checker.sv
tb/tb_aliquot_sum_perfect_test.sv
